// ===== hdl/pidc_pkg.sv =====
// Shared types, codes, constants, saturating helpers and magnitude helpers for the PID step core.
package pidc_pkg;

  // Sequencer states of the step core
  typedef enum logic [4:0] {
    S_IDLE,
    S_CHECK,
    S_XK_GO,
    S_XK_WAIT,
    S_XM_GO,
    S_XM_WAIT,
    S_XD_GO,
    S_XD_WAIT,
    S_XFIN,
    S_DEAD,
    S_MI_GO,
    S_MI_WAIT,
    S_DD_GO,
    S_DD_WAIT,
    S_MP_GO,
    S_MP_WAIT,
    S_MQ_GO,
    S_MQ_WAIT,
    S_MD_GO,
    S_MD_WAIT,
    S_FIN,
    S_DONE
  } state_e;

  // Result status codes
  typedef enum logic [2:0] {
    STAT_OK         = 3'd0,
    STAT_DEADBAND   = 3'd1,
    STAT_BAD_STEP   = 3'd2,
    STAT_BAD_LIMITS = 3'd3,
    STAT_CLEARED    = 3'd4
  } status_e;

  // Error shaping modes
  typedef enum logic [1:0] {
    MODE_PLAIN = 2'd0,
    MODE_EXP   = 2'd1,
    MODE_WRAP  = 2'd2
  } mode_e;

  // Register indexes
  typedef enum logic [2:0] {
    REG_GAIN_P     = 3'd0,
    REG_GAIN_I     = 3'd1,
    REG_GAIN_D     = 3'd2,
    REG_LIMIT_LOW  = 3'd3,
    REG_LIMIT_HIGH = 3'd4,
    REG_DEAD_ZONE  = 3'd5,
    REG_ERROR_MODE = 3'd6
  } reg_e;

  localparam logic CMD_CLEAR = 1'b1;

  localparam int          ADDR_W    = 5;
  localparam logic [63:0] LN2_Q32   = 64'd2977044472;
  localparam logic [3:0]  EXP_TERMS = 4'd12;
  localparam logic [6:0]  DIV_FULL  = 7'd64;
  localparam logic [6:0]  DIV_HALF  = 7'd32;

  localparam logic signed [31:0] I32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] I32_NMAX = 32'sh8000_0001;
  localparam logic signed [63:0] I64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] I64_MIN = 64'sh8000_0000_0000_0000;

  // Configuration register file contents
  typedef struct packed {
    logic signed [31:0] gain_p;
    logic signed [31:0] gain_i;
    logic signed [31:0] gain_d;
    logic signed [31:0] limit_low;
    logic signed [31:0] limit_high;
    logic [30:0]        dead_zone;
    logic [1:0]         error_mode;
  } cfg_t;

  // Multiplier request and response
  typedef struct packed {
    logic        start;
    logic        neg;
    logic [63:0] a;
    logic [31:0] b;
  } mul_req_t;

  typedef struct packed {
    logic               done;
    logic [95:0]        prod;
    logic signed [63:0] res;
  } mul_rsp_t;

  // Divider request and response
  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [31:0] divisor;
    logic [6:0]  iters;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quot;
    logic [31:0] rem;
  } div_rsp_t;

  // Saturate a 64 bit value to the signed 32 bit range
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      r = I32_MAX;
    end else if (v < 64'shFFFF_FFFF_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Saturating signed 64 bit add
  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    logic signed [63:0] r;
    s = 65'(a) + 65'(b);
    if (s[64] != s[63]) begin
      r = s[64] ? I64_MIN : I64_MAX;
    end else begin
      r = s[63:0];
    end
    return r;
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    return v[63] ? (~v + 64'd1) : v;
  endfunction

endpackage

// ===== hdl/pidc_regs.sv =====
// Configuration register file with APB-style write and read access.
module pidc_regs #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic [pidc_pkg::ADDR_W-1:0]   paddr_i,
  input  logic [31:0]                   pwdata_i,
  output logic [31:0]                   prdata_o,
  output pidc_pkg::cfg_t                cfg_o
);

  localparam logic signed [31:0] OneQ = 32'sd1 <<< FRAC_BITS;

  pidc_pkg::cfg_t cfg_q;
  logic [2:0]     idx;
  logic           wr_en;

  assign idx   = paddr_i[pidc_pkg::ADDR_W-1:2];
  assign wr_en = psel_i && penable_i && pwrite_i;

  // Write registers on the access cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p     <= '0;
      cfg_q.gain_i     <= '0;
      cfg_q.gain_d     <= '0;
      cfg_q.limit_low  <= -OneQ;
      cfg_q.limit_high <= OneQ;
      cfg_q.dead_zone  <= '0;
      cfg_q.error_mode <= '0;
    end else if (wr_en) begin
      case (idx)
        pidc_pkg::REG_GAIN_P:     cfg_q.gain_p     <= pwdata_i;
        pidc_pkg::REG_GAIN_I:     cfg_q.gain_i     <= pwdata_i;
        pidc_pkg::REG_GAIN_D:     cfg_q.gain_d     <= pwdata_i;
        pidc_pkg::REG_LIMIT_LOW:  cfg_q.limit_low  <= pwdata_i;
        pidc_pkg::REG_LIMIT_HIGH: cfg_q.limit_high <= pwdata_i;
        pidc_pkg::REG_DEAD_ZONE:  cfg_q.dead_zone  <= pwdata_i[30:0];
        pidc_pkg::REG_ERROR_MODE: cfg_q.error_mode <= pwdata_i[1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (idx)
      pidc_pkg::REG_GAIN_P:     prdata_o = cfg_q.gain_p;
      pidc_pkg::REG_GAIN_I:     prdata_o = cfg_q.gain_i;
      pidc_pkg::REG_GAIN_D:     prdata_o = cfg_q.gain_d;
      pidc_pkg::REG_LIMIT_LOW:  prdata_o = cfg_q.limit_low;
      pidc_pkg::REG_LIMIT_HIGH: prdata_o = cfg_q.limit_high;
      pidc_pkg::REG_DEAD_ZONE:  prdata_o = {1'b0, cfg_q.dead_zone};
      pidc_pkg::REG_ERROR_MODE: prdata_o = {30'd0, cfg_q.error_mode};
      default:                  prdata_o = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/pidc_mul.sv =====
// Shared 64x32 magnitude multiplier: two 32x32 partial products, then Q scaling.
module pidc_mul #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pidc_pkg::mul_req_t req_i,
  output pidc_pkg::mul_rsp_t rsp_o
);

  logic [2:0]         cnt_q;
  logic               done_q;
  logic [63:0]        a_q;
  logic [31:0]        b_q;
  logic               neg_q;
  logic [63:0]        pp_q;
  logic [63:0]        lo_q;
  logic [95:0]        prod_q;
  logic signed [63:0] res_q;
  logic [63:0]        m;
  logic signed [63:0] res_d;

  // Scale the product and restore the sign, saturating on overflow
  always_comb begin
    if (prod_q[95:64] != '0) begin
      m = '1;
    end else begin
      m = prod_q[63:0] >> FRAC_BITS;
    end
    if (!neg_q) begin
      res_d = m[63] ? pidc_pkg::I64_MAX : m;
    end else if (m[63]) begin
      res_d = pidc_pkg::I64_MIN;
    end else begin
      res_d = ~m + 64'd1;
    end
  end

  // Sequence control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == 3'd4);
      if (req_i.start) begin
        cnt_q <= 3'd1;
      end else if (cnt_q == 3'd4) begin
        cnt_q <= '0;
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q + 3'd1;
      end
    end
  end

  // Partial products and accumulation
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q   <= req_i.a;
      b_q   <= req_i.b;
      neg_q <= req_i.neg;
    end
    case (cnt_q)
      3'd1: pp_q <= a_q[31:0] * b_q;
      3'd2: begin
        lo_q <= pp_q;
        pp_q <= a_q[63:32] * b_q;
      end
      3'd3: prod_q <= {32'd0, lo_q} + {pp_q, 32'd0};
      3'd4: res_q <= res_d;
      default: ;
    endcase
  end

  assign rsp_o.done = done_q;
  assign rsp_o.prod = prod_q;
  assign rsp_o.res  = res_q;

endmodule

// ===== hdl/pidc_div.sv =====
// Shared restoring divider, one quotient bit per cycle, 32 bit divisor.
module pidc_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pidc_pkg::div_req_t req_i,
  output pidc_pkg::div_rsp_t rsp_o
);

  logic [6:0]  cnt_q;
  logic        done_q;
  logic [63:0] dq_q;
  logic [31:0] rem_q;
  logic [31:0] d_q;
  logic [32:0] trial;
  logic [32:0] diff;
  logic        ge;

  // One restoring step
  assign trial = {rem_q, dq_q[63]};
  assign ge    = trial >= {1'b0, d_q};
  assign diff  = trial - {1'b0, d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == 7'd1);
      if (req_i.start) begin
        cnt_q <= req_i.iters;
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 7'd1;
      end
    end
  end

  // Shift the quotient bit in as the dividend bit leaves
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dq_q  <= req_i.dividend;
      d_q   <= req_i.divisor;
      rem_q <= '0;
    end else if (cnt_q != '0) begin
      rem_q <= ge ? diff[31:0] : trial[31:0];
      dq_q  <= {dq_q[62:0], ge};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = dq_q;
  assign rsp_o.rem  = rem_q;

endmodule

// ===== hdl/pid_controller_step_core.sv =====
// Top level: PID step sequencer driving a shared multiplier and a shared divider.
//
//  channel   | dir | handshake          | payload
//  ----------+-----+--------------------+---------------------------------------
//  s_axis    | in  | tvalid/tready      | tdata: time_step, setpoint, measured
//            |     |                    | tuser: command
//  m_axis    | out | tvalid/tready      | tdata: drive; tuser: status
//  apb       | in  | psel/penable/pwrite| paddr, pwdata -> prdata, pready
//
// In a run step the full-width derivative division dominates. Exponential
// shaping adds one multiply and one 32 step divide per series term. Clear
// and error items skip the arithmetic units.
// One item is in work at a time; s_axis_tready is high only when idle. The
// result sits in an output register, so a new item is taken while it waits.
// Reset is asynchronous, active low; no clearing pass is needed.
module pid_controller_step_core #(
  parameter int FRAC_BITS = 16,
  parameter int ACC_WIDTH = 48
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [95:0]                 s_axis_tdata,  // time_step, setpoint, measured
  input  logic [0:0]                  s_axis_tuser,  // command
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [31:0]                 m_axis_tdata,  // drive
  output logic [2:0]                  m_axis_tuser,  // status
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pidc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int          XqShift = 32 - FRAC_BITS;
  localparam logic [63:0] XqMax   = 64'(XqShift) * pidc_pkg::LN2_Q32;
  localparam logic signed [63:0] AccHi =
    64'((65'sd1 <<< (ACC_WIDTH - 1)) - 65'sd1);
  localparam logic signed [63:0] AccLo = -AccHi - 64'sd1;
  localparam logic [63:0] OneQ = 64'd1 << FRAC_BITS;

  pidc_pkg::cfg_t     cfg;
  pidc_pkg::mul_req_t mul_req;
  pidc_pkg::mul_rsp_t mul_rsp;
  pidc_pkg::div_req_t div_req;
  pidc_pkg::div_rsp_t div_rsp;

  pidc_pkg::state_e   state_q, state_d;

  logic                      cmd_q;
  logic signed [31:0]        dt_q, sp_q, pv_q;
  logic signed [31:0]        err_q;
  logic [4:0]                k_q;
  logic [31:0]               r_q;
  logic [32:0]               term_q;
  logic [33:0]               sum_q;
  logic [3:0]                n_q;
  logic signed [63:0]        integ_q, deriv_q, drive_q;
  logic [2:0]                stat_q;
  logic signed [ACC_WIDTH-1:0] acc_q;
  logic signed [31:0]        last_q;
  logic                      out_valid_q;
  logic [31:0]               out_data_q;
  logic [2:0]                out_stat_q;

  logic                      s_acc;
  logic                      out_load;
  logic signed [31:0]        err_raw;
  logic                      err_neg;
  logic [31:0]               err_mag;
  logic [63:0]               xq;
  logic                      xq_big;
  logic [63:0]               exp_shl, exp_res;
  logic [31:0]               exp_sat, exp_err;
  logic                      inband;
  logic signed [31:0]        wrap_err;
  logic signed [63:0]        acc_ext, integ_cand, integ_clamp;
  logic signed [63:0]        diff, dshift;
  logic [63:0]               dmag;
  logic signed [63:0]        deriv_d;
  logic signed [63:0]        ll_ext, lh_ext;
  logic                      drive_lo, drive_hi;
  logic                      bad_step, bad_lim;

  pidc_regs #(.FRAC_BITS(FRAC_BITS)) u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .cfg_o     (cfg)
  );

  pidc_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  pidc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign pready        = 1'b1;
  assign s_axis_tready = (state_q == pidc_pkg::S_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state_q == pidc_pkg::S_DONE) && (!out_valid_q || m_axis_tready);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_stat_q;

  // Error and its magnitude
  assign err_raw = pidc_pkg::sat32(64'(sp_q) - 64'(pv_q));
  assign err_neg = err_q[31];
  assign err_mag = pidc_pkg::mag32(err_q);

  // Exponential shaping: range check and final scaling
  assign xq      = 64'(err_mag) << XqShift;
  assign xq_big  = xq >= XqMax;
  assign exp_shl = 64'(sum_q) << k_q;
  assign exp_res = (exp_shl >> XqShift) - OneQ;
  assign exp_sat = (exp_res > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : exp_res[31:0];
  assign exp_err = err_neg ? (~exp_sat + 32'd1) : exp_sat;

  // Deadband and wrap
  assign inband = (cfg.dead_zone != '0) && ({1'b0, cfg.dead_zone} > err_mag);
  assign ll_ext = 64'(cfg.limit_low);
  assign lh_ext = 64'(cfg.limit_high);
  always_comb begin
    if (err_q < cfg.limit_low) begin
      wrap_err = pidc_pkg::sat32(64'(err_q) + (lh_ext <<< 1));
    end else if (err_q > cfg.limit_high) begin
      wrap_err = pidc_pkg::sat32(64'(err_q) + (ll_ext <<< 1));
    end else begin
      wrap_err = err_q;
    end
  end

  // Integrator candidate
  assign acc_ext     = 64'(acc_q);
  assign integ_cand  = pidc_pkg::sat_add(acc_ext, mul_rsp.res);
  assign integ_clamp = (integ_cand > AccHi) ? AccHi :
                       (integ_cand < AccLo) ? AccLo : integ_cand;

  // Derivative on measurement
  assign diff    = 64'(pv_q) - 64'(last_q);
  assign dshift  = diff <<< FRAC_BITS;
  assign dmag    = pidc_pkg::mag64(dshift);
  assign deriv_d = diff[63] ? (~div_rsp.quot + 64'd1) : div_rsp.quot;

  assign drive_lo = drive_q < ll_ext;
  assign drive_hi = drive_q > lh_ext;
  assign bad_step = dt_q <= 32'sd0;
  assign bad_lim  = cfg.limit_low >= cfg.limit_high;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      pidc_pkg::S_IDLE:    if (s_acc) state_d = pidc_pkg::S_CHECK;
      pidc_pkg::S_CHECK: begin
        if (cmd_q == pidc_pkg::CMD_CLEAR || bad_step || bad_lim) begin
          state_d = pidc_pkg::S_DONE;
        end else if (cfg.error_mode == pidc_pkg::MODE_EXP) begin
          state_d = pidc_pkg::S_XK_GO;
        end else begin
          state_d = pidc_pkg::S_DEAD;
        end
      end
      pidc_pkg::S_XK_GO:   state_d = xq_big ? pidc_pkg::S_DEAD : pidc_pkg::S_XK_WAIT;
      pidc_pkg::S_XK_WAIT: if (div_rsp.done) state_d = pidc_pkg::S_XM_GO;
      pidc_pkg::S_XM_GO:   state_d = pidc_pkg::S_XM_WAIT;
      pidc_pkg::S_XM_WAIT: if (mul_rsp.done) state_d = pidc_pkg::S_XD_GO;
      pidc_pkg::S_XD_GO:   state_d = pidc_pkg::S_XD_WAIT;
      pidc_pkg::S_XD_WAIT: begin
        if (div_rsp.done) begin
          state_d = (n_q == pidc_pkg::EXP_TERMS) ? pidc_pkg::S_XFIN : pidc_pkg::S_XM_GO;
        end
      end
      pidc_pkg::S_XFIN:    state_d = pidc_pkg::S_DEAD;
      pidc_pkg::S_DEAD:    state_d = inband ? pidc_pkg::S_DONE : pidc_pkg::S_MI_GO;
      pidc_pkg::S_MI_GO:   state_d = pidc_pkg::S_MI_WAIT;
      pidc_pkg::S_MI_WAIT: if (mul_rsp.done) state_d = pidc_pkg::S_DD_GO;
      pidc_pkg::S_DD_GO:   state_d = pidc_pkg::S_DD_WAIT;
      pidc_pkg::S_DD_WAIT: if (div_rsp.done) state_d = pidc_pkg::S_MP_GO;
      pidc_pkg::S_MP_GO:   state_d = pidc_pkg::S_MP_WAIT;
      pidc_pkg::S_MP_WAIT: if (mul_rsp.done) state_d = pidc_pkg::S_MQ_GO;
      pidc_pkg::S_MQ_GO:   state_d = pidc_pkg::S_MQ_WAIT;
      pidc_pkg::S_MQ_WAIT: if (mul_rsp.done) state_d = pidc_pkg::S_MD_GO;
      pidc_pkg::S_MD_GO:   state_d = pidc_pkg::S_MD_WAIT;
      pidc_pkg::S_MD_WAIT: if (mul_rsp.done) state_d = pidc_pkg::S_FIN;
      pidc_pkg::S_FIN:     state_d = pidc_pkg::S_DONE;
      pidc_pkg::S_DONE:    if (out_load) state_d = pidc_pkg::S_IDLE;
      default:             state_d = pidc_pkg::S_IDLE;
    endcase
  end

  // Unit requests
  always_comb begin
    mul_req.start = 1'b0;
    mul_req.neg   = 1'b0;
    mul_req.a     = 64'(err_mag);
    mul_req.b     = dt_q;
    div_req.start    = 1'b0;
    div_req.dividend = dmag;
    div_req.divisor  = dt_q;
    div_req.iters    = pidc_pkg::DIV_FULL;
    case (state_q)
      pidc_pkg::S_XK_GO: begin
        div_req.start    = !xq_big;
        div_req.dividend = xq;
        div_req.divisor  = pidc_pkg::LN2_Q32[31:0];
      end
      pidc_pkg::S_XM_GO: begin
        mul_req.start = 1'b1;
        mul_req.a     = 64'(term_q);
        mul_req.b     = r_q;
      end
      pidc_pkg::S_XD_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = {mul_rsp.prod[63:32], 32'd0};
        div_req.divisor  = 32'(n_q);
        div_req.iters    = pidc_pkg::DIV_HALF;
      end
      pidc_pkg::S_MI_GO: begin
        mul_req.start = 1'b1;
        mul_req.neg   = err_neg;
      end
      pidc_pkg::S_DD_GO: div_req.start = 1'b1;
      pidc_pkg::S_MP_GO: begin
        mul_req.start = 1'b1;
        mul_req.neg   = err_neg ^ cfg.gain_p[31];
        mul_req.b     = pidc_pkg::mag32(cfg.gain_p);
      end
      pidc_pkg::S_MQ_GO: begin
        mul_req.start = 1'b1;
        mul_req.neg   = integ_q[63] ^ cfg.gain_i[31];
        mul_req.a     = pidc_pkg::mag64(integ_q);
        mul_req.b     = pidc_pkg::mag32(cfg.gain_i);
      end
      pidc_pkg::S_MD_GO: begin
        mul_req.start = 1'b1;
        mul_req.neg   = deriv_q[63] ^ cfg.gain_d[31];
        mul_req.a     = pidc_pkg::mag64(deriv_q);
        mul_req.b     = pidc_pkg::mag32(cfg.gain_d);
      end
      default: ;
    endcase
  end

  // Control and controller state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pidc_pkg::S_IDLE;
      out_valid_q <= 1'b0;
      acc_q       <= '0;
      last_q      <= '0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == pidc_pkg::S_CHECK && cmd_q == pidc_pkg::CMD_CLEAR) begin
        acc_q  <= '0;
        last_q <= '0;
      end
      if (state_q == pidc_pkg::S_FIN) begin
        last_q <= pv_q;
        if (!drive_lo && !drive_hi) begin
          acc_q <= ACC_WIDTH'(integ_q);
        end
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      pidc_pkg::S_IDLE: begin
        if (s_acc) begin
          cmd_q <= s_axis_tuser[0];
          dt_q  <= s_axis_tdata[31:0];
          sp_q  <= s_axis_tdata[63:32];
          pv_q  <= s_axis_tdata[95:64];
        end
      end
      pidc_pkg::S_CHECK: begin
        err_q   <= err_raw;
        drive_q <= '0;
        if (cmd_q == pidc_pkg::CMD_CLEAR) begin
          stat_q <= pidc_pkg::STAT_CLEARED;
        end else if (bad_step) begin
          stat_q <= pidc_pkg::STAT_BAD_STEP;
        end else if (bad_lim) begin
          stat_q <= pidc_pkg::STAT_BAD_LIMITS;
        end else begin
          stat_q <= pidc_pkg::STAT_OK;
        end
      end
      pidc_pkg::S_XK_GO: begin
        if (xq_big) begin
          err_q <= err_neg ? pidc_pkg::I32_NMAX : pidc_pkg::I32_MAX;
        end
      end
      pidc_pkg::S_XK_WAIT: begin
        if (div_rsp.done) begin
          k_q    <= div_rsp.quot[4:0];
          r_q    <= div_rsp.rem;
          term_q <= 33'h1_0000_0000;
          sum_q  <= 34'h1_0000_0000;
          n_q    <= 4'd1;
        end
      end
      pidc_pkg::S_XD_WAIT: begin
        if (div_rsp.done) begin
          term_q <= 33'(div_rsp.quot[31:0]);
          sum_q  <= sum_q + 34'(div_rsp.quot[31:0]);
          n_q    <= n_q + 4'd1;
        end
      end
      pidc_pkg::S_XFIN: err_q <= exp_err;
      pidc_pkg::S_DEAD: begin
        if (inband) begin
          stat_q <= pidc_pkg::STAT_DEADBAND;
        end else if (cfg.error_mode == pidc_pkg::MODE_WRAP) begin
          err_q <= wrap_err;
        end
      end
      pidc_pkg::S_MI_WAIT: if (mul_rsp.done) integ_q <= integ_clamp;
      pidc_pkg::S_DD_WAIT: if (div_rsp.done) deriv_q <= deriv_d;
      pidc_pkg::S_MP_WAIT: if (mul_rsp.done) drive_q <= mul_rsp.res;
      pidc_pkg::S_MQ_WAIT: begin
        if (mul_rsp.done) drive_q <= pidc_pkg::sat_add(drive_q, mul_rsp.res);
      end
      pidc_pkg::S_MD_WAIT: begin
        if (mul_rsp.done) drive_q <= pidc_pkg::sat_add(drive_q, mul_rsp.res);
      end
      pidc_pkg::S_FIN: begin
        if (drive_lo) begin
          drive_q <= ll_ext;
        end else if (drive_hi) begin
          drive_q <= lh_ext;
        end
      end
      default: ;
    endcase
    if (out_load) begin
      out_data_q <= drive_q[31:0];
      out_stat_q <= stat_q;
    end
  end

endmodule

// ===== hdl/pidc_chk.sv =====
// Port-level checker for the PID step core, bound to the top level.
module pidc_chk (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        s_axis_tvalid,
  input logic                        s_axis_tready,
  input logic [95:0]                 s_axis_tdata,
  input logic [0:0]                  s_axis_tuser,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [31:0]                 m_axis_tdata,
  input logic [2:0]                  m_axis_tuser,
  input logic                        psel,
  input logic                        penable,
  input logic                        pwrite,
  input logic [pidc_pkg::ADDR_W-1:0] paddr,
  input logic [31:0]                 pwdata,
  input logic [31:0]                 prdata,
  input logic                        pready
);

  // One item at a time: ready drops after a transaction
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready stayed high after a transaction");

  // Status stays within the defined codes
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser <= pidc_pkg::STAT_CLEARED)
    else $error("undefined status code");

  // Drive is zero unless the step completed
  a_zero_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != pidc_pkg::STAT_OK |-> m_axis_tdata == '0)
    else $error("nonzero drive with error status");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // Register port never waits
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind pid_controller_step_core pidc_chk u_pidc_chk (.*);
